FILE: rtl/jtok_pkg.sv
package jtok_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_STRING = 2'd1,
      MODE_ESCAPE = 2'd2,
      MODE_PRIM   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_OBJECT = 2'd0,
      KIND_ARRAY  = 2'd1,
      KIND_STRING = 2'd2,
      KIND_PRIM   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_SYNTAX = 2'd1,
      ERR_FULL   = 2'd2,
      ERR_LONG   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_CHILD,
      ST_DUMP_RD,
      ST_DUMP_OUT,
      ST_ERR_OUT
   } fsm_type;

   localparam logic [7:0] CH_LBRACE    = 8'h7b;
   localparam logic [7:0] CH_RBRACE    = 8'h7d;
   localparam logic [7:0] CH_LBRACKET  = 8'h5b;
   localparam logic [7:0] CH_RBRACKET  = 8'h5d;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_COLON     = 8'h3a;
   localparam logic [7:0] CH_COMMA     = 8'h2c;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0d;
   localparam logic [7:0] CH_LF        = 8'h0a;

   localparam logic [5:0] LIMIT_RESET  = 6'd32;
   localparam logic [1:0] REG_TOKEN_LIMIT = 2'd0;

endpackage

FILE: rtl/json_tokenizer.sv
// json_tokenizer: jsmn-style json tokenizer
// req_ channel: one document byte per word, req_tlast marks the final byte
// rsp_ channel: on the final byte the token table is streamed out, one word
// per token in slot order, or a single word for an error or an empty table;
// rsp_tlast marks the last word of the run
// csr_ port: register 0 (address 0) is token_limit, reset 32
// flow: a byte that touches no table entry is done when taken; a byte that
// adds a token under a container does the token write and parent read, then
// the parent child-count write-back in ST_CHILD; a closer does a container
// read, then the write-back in ST_CLOSE; a primitive ended by a closer also
// uses ST_CHILD, the child count and the close share one write-back
// result path: an error or empty-table word is loaded into the output register
// in ST_ERR_OUT; each token word takes a table read in ST_DUMP_RD and a load in
// ST_DUMP_OUT, after the write-back when the final byte needs one
// stalls: every word waits in the output register until the receiver takes
// it, so a stalled receiver stalls the dump; no byte is taken during a dump
// reset clears the scanner and restores token_limit to 32
module json_tokenizer
   import jtok_pkg::*;
#(
   parameter int TABLE_DEPTH   = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_in
   input  logic        req_tlast,   // doc_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], token_total[7:2], token_slot[12:8], token_kind[14:13],
   // start_offset[30:15], end_offset[46:31], children[51:47],
   // parent_slot[57:52], zero fill [63:58]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,   // final_result
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = IW + 1;
   localparam int PW = POSITION_BITS;
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

   typedef struct packed {
      logic [1:0]    kind;
      logic [PW-1:0] start;
      logic [PW-1:0] stop;
      logic [4:0]    children;
      logic          has_parent;
      logic [IW-1:0] parent;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;

   logic          mem_we, mem_re;
   logic [IW-1:0] mem_wa, mem_ra;
   entry_type     mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   fsm_type       fsm_ff, fsm_in;
   mode_type      mode_ff, mode_in;
   logic [PW-1:0] pos_ff, pos_in, pend_ff, pend_in;
   logic [CW-1:0] used_ff, used_in;
   logic          cur_ok_ff, cur_ok_in;
   logic [IW-1:0] cur_ff, cur_in;
   err_type       err_ff, err_in;
   logic [5:0]    limit_ff;
   logic [7:0]    chr_ff, chr_in;
   logic          last_ff, last_in;
   logic          close_ff, close_in;
   logic [IW-1:0] par_ff, par_in;
   logic [CW-1:0] dump_ff, dump_in;
   logic          ov_ff, ov_in;
   logic [63:0]   od_ff, od_in;
   logic          ol_ff, ol_in;

   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == REG_TOKEN_LIMIT) ? {26'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_RESET;
      else if (csr_wr && csr_paddr == REG_TOKEN_LIMIT) limit_ff <= csr_pwdata[5:0];
   end

   logic [CW-1:0] limit_eff;
   assign limit_eff = (int'(limit_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(limit_ff);

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ol_ff;

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE;
   endfunction

   logic acc;
   assign acc = req_tvalid && req_tready;

   always_comb begin
      logic [7:0] c;
      logic full, go_idle, finish, dly, prim;
      err_type e;
      kind_type want;
      fsm_in = fsm_ff; mode_in = mode_ff; pos_in = pos_ff; pend_in = pend_ff;
      used_in = used_ff; cur_ok_in = cur_ok_ff; cur_in = cur_ff; err_in = err_ff;
      chr_in = chr_ff; last_in = last_ff; close_in = close_ff; par_in = par_ff;
      dump_in = dump_ff; ov_in = ov_ff; od_in = od_ff; ol_in = ol_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_wa = used_ff[IW-1:0]; mem_ra = cur_ff;
      mem_wd = '0;
      req_tready = 1'b0;
      c = req_tdata;
      full = used_ff >= limit_eff;
      go_idle = 1'b0; finish = 1'b0; dly = 1'b0; prim = 1'b0;
      e = ERR_NONE;
      want = (chr_ff == CH_RBRACE) ? KIND_OBJECT : KIND_ARRAY;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (fsm_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (acc) begin
               chr_in = c; last_in = req_tlast;
               if (err_ff == ERR_NONE) begin
                  if (pos_ff == POS_MAX) err_in = ERR_LONG;
                  else begin
                     pos_in = pos_ff + 1'b1;
                     case (mode_ff)
                        MODE_STRING: begin
                           if (c == CH_QUOTE) begin
                              mode_in = MODE_IDLE;
                              if (full) err_in = ERR_FULL;
                              else begin
                                 mem_we = 1'b1;
                                 mem_wd = '{KIND_STRING, pend_ff, pos_ff, 5'd0,
                                            cur_ok_ff, cur_ff};
                                 used_in = used_ff + 1'b1;
                                 if (cur_ok_ff) begin
                                    mem_re = 1'b1; par_in = cur_ff; dly = 1'b1;
                                    fsm_in = ST_CHILD;
                                 end
                              end
                           end else if (c == CH_BACKSLASH) mode_in = MODE_ESCAPE;
                        end
                        MODE_ESCAPE: mode_in = MODE_STRING;
                        MODE_PRIM: begin
                           if (is_space(c) || c == CH_COMMA || c == CH_RBRACKET ||
                               c == CH_RBRACE) begin
                              mode_in = MODE_IDLE;
                              if (full) err_in = ERR_FULL;
                              else begin
                                 mem_we = 1'b1;
                                 mem_wd = '{KIND_PRIM, pend_ff, pos_ff, 5'd0,
                                            cur_ok_ff, cur_ff};
                                 used_in = used_ff + 1'b1;
                                 if (cur_ok_ff) begin
                                    mem_re = 1'b1; par_in = cur_ff; dly = 1'b1;
                                    fsm_in = ST_CHILD;
                                 end
                                 if (c == CH_RBRACKET || c == CH_RBRACE) begin
                                    // the parent is the container being closed
                                    if (!cur_ok_ff) err_in = ERR_SYNTAX;
                                    else close_in = 1'b1;
                                 end
                              end
                           end else if (c < CH_SPACE) err_in = ERR_SYNTAX;
                        end
                        default: go_idle = 1'b1;
                     endcase
                     if (go_idle) begin
                        if (c == CH_LBRACE || c == CH_LBRACKET) begin
                           if (full) err_in = ERR_FULL;
                           else begin
                              mem_we = 1'b1;
                              mem_wd = '{(c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY,
                                         pos_ff, PW'(0), 5'd0, cur_ok_ff, cur_ff};
                              used_in = used_ff + 1'b1;
                              cur_ok_in = 1'b1; cur_in = used_ff[IW-1:0];
                              if (cur_ok_ff) begin
                                 mem_re = 1'b1; par_in = cur_ff; dly = 1'b1;
                                 fsm_in = ST_CHILD;
                              end
                           end
                        end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
                           if (!cur_ok_ff) err_in = ERR_SYNTAX;
                           else begin
                              mem_re = 1'b1; mem_ra = cur_ff;
                              dly = 1'b1; fsm_in = ST_CLOSE;
                           end
                        end else if (c == CH_QUOTE) begin
                           pend_in = pos_ff + 1'b1; mode_in = MODE_STRING;
                        end else if (is_space(c) || c == CH_COLON || c == CH_COMMA) begin
                        end else if (c < CH_SPACE) err_in = ERR_SYNTAX;
                        else begin
                           pend_in = pos_ff; mode_in = MODE_PRIM;
                        end
                     end
                  end
               end
               if (!dly && req_tlast) finish = 1'b1;
            end
         end
         ST_CHILD: begin
            // parent child-count write-back, plus the close after a primitive
            mem_we = 1'b1; mem_wa = par_ff;
            mem_wd = rd_ff;
            mem_wd.children = rd_ff.children + 5'd1;
            if (close_ff) begin
               if (rd_ff.kind != want) err_in = ERR_SYNTAX;
               else begin
                  mem_wd.stop = pos_ff;
                  cur_ok_in = rd_ff.has_parent; cur_in = rd_ff.parent;
               end
            end
            close_in = 1'b0;
            fsm_in = ST_IDLE;
            finish = last_ff;
         end
         ST_CLOSE: begin
            if (rd_ff.kind != want) err_in = ERR_SYNTAX;
            else begin
               mem_we = 1'b1; mem_wa = cur_ff;
               mem_wd = rd_ff;
               mem_wd.stop = pos_ff;
               cur_ok_in = rd_ff.has_parent; cur_in = rd_ff.parent;
            end
            fsm_in = ST_IDLE;
            finish = last_ff;
         end
         ST_DUMP_RD: begin
            mem_re = 1'b1; mem_ra = dump_ff[IW-1:0];
            fsm_in = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               od_in = {6'd0, rd_ff.has_parent ? 6'(rd_ff.parent) : 6'h3f,
                        rd_ff.children, 16'(rd_ff.stop), 16'(rd_ff.start), rd_ff.kind,
                        5'(dump_ff), 6'(used_ff), ERR_NONE};
               ol_in = (dump_ff + 1'b1 == used_ff);
               dump_in = dump_ff + 1'b1;
               if (dump_ff + 1'b1 == used_ff) begin
                  fsm_in = ST_IDLE;
                  mode_in = MODE_IDLE; pos_in = '0; used_in = '0; cur_ok_in = 1'b0;
                  cur_in = '0; pend_in = '0; err_in = ERR_NONE;
               end else fsm_in = ST_DUMP_RD;
            end
         end
         ST_ERR_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; ol_in = 1'b1; od_in = {62'd0, err_ff};
               mode_in = MODE_IDLE; pos_in = '0; used_in = '0; cur_ok_in = 1'b0;
               cur_in = '0; pend_in = '0; err_in = ERR_NONE;
               fsm_in = ST_IDLE;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase

      if (finish) begin
         e = err_in;
         if (e == ERR_NONE) begin
            if (mode_in == MODE_STRING || mode_in == MODE_ESCAPE) e = ERR_SYNTAX;
            else if (mode_in == MODE_PRIM) begin
               if (used_in >= limit_eff) e = ERR_FULL;
               else if (cur_ok_in) e = ERR_SYNTAX;
               else prim = 1'b1;
            end
         end
         if (e == ERR_NONE && cur_ok_in) e = ERR_SYNTAX;
         if (prim) begin
            // trailing primitive at top level
            mem_we = 1'b1; mem_wa = used_in[IW-1:0];
            mem_wd = '{KIND_PRIM, pend_in, pos_in, 5'd0, 1'b0, '0};
            used_in = used_in + 1'b1;
         end
         if (e != ERR_NONE || used_in == '0) begin
            err_in = e; fsm_in = ST_ERR_OUT;
         end else begin
            dump_in = '0; fsm_in = ST_DUMP_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= ST_IDLE; mode_ff <= MODE_IDLE; pos_ff <= '0; pend_ff <= '0;
         used_ff <= '0; cur_ok_ff <= 1'b0; cur_ff <= '0; err_ff <= ERR_NONE;
         last_ff <= 1'b0; close_ff <= 1'b0; dump_ff <= '0; ov_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in; mode_ff <= mode_in; pos_ff <= pos_in; pend_ff <= pend_in;
         used_ff <= used_in; cur_ok_ff <= cur_ok_in; cur_ff <= cur_in; err_ff <= err_in;
         last_ff <= last_in; close_ff <= close_in; dump_ff <= dump_in; ov_ff <= ov_in;
      end
   end
   always_ff @(posedge clock) begin
      chr_ff <= chr_in; par_ff <= par_in; od_ff <= od_in; ol_ff <= ol_in;
   end

   property p_out_hold;
      @(posedge clock) disable iff (reset)
         ov_ff && !rsp_tready |=> ov_ff && $stable(od_ff);
   endproperty
   a_out_hold: assert property (p_out_hold) else $error("output word dropped");

   property p_dump_no_input;
      @(posedge clock) disable iff (reset)
         (fsm_ff == ST_DUMP_RD || fsm_ff == ST_DUMP_OUT || fsm_ff == ST_ERR_OUT)
            |-> !req_tready;
   endproperty
   a_dump_no_input: assert property (p_dump_no_input) else $error("input taken in dump");

   property p_used_bound;
      @(posedge clock) disable iff (reset) used_ff <= CW'(TABLE_DEPTH);
   endproperty
   a_used_bound: assert property (p_used_bound) else $error("token count overflow");

   property p_close_busy;
      @(posedge clock) disable iff (reset)
         (fsm_ff == ST_CLOSE || fsm_ff == ST_CHILD) |-> !req_tready;
   endproperty
   a_close_busy: assert property (p_close_busy) else $error("input during rmw");

endmodule

FILE: verif/tb_json_tokenizer.sv
`timescale 1ns / 1ps

module tb_json_tokenizer;
   import jtok_pkg::*;

   typedef struct {
      int st;
      int total;
      int slot;
      int kind;
      int start_off;
      int end_off;
      int kids;
      int par;
      int fin;
   } token_word_type;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
      logic       chk;
      err_type    st;
   } doc_row_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int POS_LIMIT = 65535;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = 2'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   json_tokenizer DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // scanner copy
   int        limit_reg;
   mode_type  scan_st;
   int        pos;
   int        used;
   int        cur_box;
   int        pend_start;
   err_type   err;
   kind_type  tab_kind [32];
   int        tab_start [32];
   int        tab_end [32];
   int        tab_kids [32];
   int        tab_par [32];

   token_word_type token_q[$];
   int          fails = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet = 0;
   err_type     last_status;
   logic [7:0]  doc_q[$];

   function automatic void clear_scan();
      scan_st = MODE_IDLE;
      pos = 0;
      used = 0;
      cur_box = -1;
      pend_start = 0;
      err = ERR_NONE;
   endfunction

   function automatic int new_token(kind_type k, int s, int e);
      int lim;
      int idx;
      lim = (limit_reg < 32) ? limit_reg : 32;
      if (used >= lim) begin
         err = ERR_FULL;
         return -1;
      end
      idx = used;
      used++;
      tab_kind[idx] = k;
      tab_start[idx] = s;
      tab_end[idx] = e;
      tab_kids[idx] = 0;
      tab_par[idx] = cur_box;
      if (cur_box >= 0)
         tab_kids[cur_box] = (tab_kids[cur_box] + 1) & 31;
      return idx;
   endfunction

   function automatic bit is_ws(logic [7:0] c);
      return c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE;
   endfunction

   function automatic void scan_between(logic [7:0] c, int p);
      int idx;
      kind_type want;
      if (c == CH_LBRACE || c == CH_LBRACKET) begin
         idx = new_token(c == CH_LBRACE ? KIND_OBJECT : KIND_ARRAY, p, 0);
         if (idx >= 0)
            cur_box = idx;
      end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
         want = (c == CH_RBRACE) ? KIND_OBJECT : KIND_ARRAY;
         if (cur_box < 0 || tab_kind[cur_box] != want) begin
            err = ERR_SYNTAX;
            return;
         end
         tab_end[cur_box] = p + 1;
         cur_box = tab_par[cur_box];
      end else if (c == CH_QUOTE) begin
         pend_start = p + 1;
         scan_st = MODE_STRING;
      end else if (is_ws(c) || c == CH_COLON || c == CH_COMMA) begin
      end else if (c < 8'd32) begin
         err = ERR_SYNTAX;
      end else begin
         pend_start = p;
         scan_st = MODE_PRIM;
      end
   endfunction

   function automatic void predict_byte(logic [7:0] c, logic last);
      token_word_type w;
      if (err == ERR_NONE) begin
         if (pos >= POS_LIMIT) begin
            err = ERR_LONG;
         end else begin
            case (scan_st)
               MODE_STRING: begin
                  if (c == CH_QUOTE) begin
                     scan_st = MODE_IDLE;
                     void'(new_token(KIND_STRING, pend_start, pos));
                  end else if (c == CH_BACKSLASH) begin
                     scan_st = MODE_ESCAPE;
                  end
               end
               MODE_ESCAPE: scan_st = MODE_STRING;
               MODE_PRIM: begin
                  if (is_ws(c) || c == CH_COMMA || c == CH_RBRACKET || c == CH_RBRACE) begin
                     scan_st = MODE_IDLE;
                     if (new_token(KIND_PRIM, pend_start, pos) >= 0)
                        scan_between(c, pos);
                  end else if (c < 8'd32) begin
                     err = ERR_SYNTAX;
                  end
               end
               default: scan_between(c, pos);
            endcase
            pos++;
         end
      end
      if (!last)
         return;
      if (err == ERR_NONE) begin
         if (scan_st == MODE_STRING || scan_st == MODE_ESCAPE)
            err = ERR_SYNTAX;
         else if (scan_st == MODE_PRIM)
            void'(new_token(KIND_PRIM, pend_start, pos));
      end
      if (err == ERR_NONE && cur_box != -1)
         err = ERR_SYNTAX;
      last_status = err;
      if (err != ERR_NONE || used == 0) begin
         w = '{int'(err), 0, 0, 0, 0, 0, 0, 0, 1};
         token_q.push_back(w);
      end else begin
         for (int k = 0; k < used; k++) begin
            w.st = 0;
            w.total = used;
            w.slot = k;
            w.kind = int'(tab_kind[k]);
            w.start_off = tab_start[k] & 16'hffff;
            w.end_off = tab_end[k] & 16'hffff;
            w.kids = tab_kids[k];
            w.par = tab_par[k] & 63;
            w.fin = (k + 1 == used);
            token_q.push_back(w);
         end
      end
      clear_scan();
   endfunction

   function automatic void check_field(string nm, int e, int a);
      if (e != a) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, nm, e, a);
         fails++;
      end
   endfunction

   // result side
   always @(posedge clock) begin
      token_word_type w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (token_q.size() == 0) begin
               $display("%0t unexpected word %h", $time, rsp_tdata);
               fails++;
            end else begin
               w = token_q.pop_front();
               check_field("status", w.st, rsp_tdata[1:0]);
               check_field("token_total", w.total, rsp_tdata[7:2]);
               check_field("token_slot", w.slot, rsp_tdata[12:8]);
               check_field("token_kind", w.kind, rsp_tdata[14:13]);
               check_field("start_offset", w.start_off, rsp_tdata[30:15]);
               check_field("end_offset", w.end_off, rsp_tdata[46:31]);
               check_field("children", w.kids, rsp_tdata[51:47]);
               check_field("parent_slot", w.par, rsp_tdata[57:52]);
               check_field("final_result", w.fin, rsp_tlast);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] c, logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_byte(c, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (token_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_limit(int v);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_TOKEN_LIMIT;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      limit_reg = v & 63;
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
      return c;
   endfunction

   function automatic logic [7:0] prim_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(8'h30, 8'h39));
         1: return 8'($urandom_range(8'h61, 8'h7a));
         2: return 8'h2d;
         default: return 8'h2e;
      endcase
   endfunction

   function automatic void build_doc();
      logic [7:0] stk[$];
      int r;
      doc_q.delete();
      repeat ($urandom_range(1, 12)) begin
         r = $urandom_range(0, 99);
         if (r < 15 && stk.size() < 5) begin
            if ($urandom_range(0, 1)) begin
               doc_q.push_back(CH_LBRACE);
               stk.push_back(CH_RBRACE);
            end else begin
               doc_q.push_back(CH_LBRACKET);
               stk.push_back(CH_RBRACKET);
            end
         end else if (r < 30 && stk.size() > 0) begin
            doc_q.push_back(stk.pop_back());
         end else if (r < 55) begin
            doc_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(0, 4) == 0) begin
                  doc_q.push_back(CH_BACKSLASH);
                  doc_q.push_back(8'($urandom_range(0, 255)));
               end else begin
                  doc_q.push_back(text_char());
               end
            end
            doc_q.push_back(CH_QUOTE);
         end else if (r < 80) begin
            repeat ($urandom_range(1, 4)) doc_q.push_back(prim_char());
         end
         case ($urandom_range(0, 5))
            0: doc_q.push_back(CH_COMMA);
            1: doc_q.push_back(CH_COLON);
            2: doc_q.push_back(CH_SPACE);
            3: doc_q.push_back($urandom_range(0, 1) ? CH_TAB : ($urandom_range(0, 1) ? CH_CR : CH_LF));
            default: ;
         endcase
      end
      if ($urandom_range(0, 9) != 0)
         while (stk.size() > 0) doc_q.push_back(stk.pop_back());
      foreach (doc_q[i])
         if ($urandom_range(0, 99) < 6)
            doc_q[i] = 8'($urandom_range(0, 255));
      if (doc_q.size() == 0)
         doc_q.push_back(CH_SPACE);
   endfunction

   doc_row_type doc_tab[22] = '{
      '{CH_LBRACE,    1'b0, 1'b0, ERR_NONE},
      '{CH_RBRACE,    1'b1, 1'b1, ERR_NONE},
      '{CH_RBRACKET,  1'b1, 1'b1, ERR_SYNTAX},
      '{CH_QUOTE,     1'b0, 1'b0, ERR_NONE},
      '{CH_BACKSLASH, 1'b1, 1'b1, ERR_SYNTAX},
      '{8'h01,        1'b1, 1'b1, ERR_SYNTAX},
      '{CH_SPACE,     1'b1, 1'b1, ERR_NONE},
      '{CH_LBRACKET,  1'b0, 1'b0, ERR_NONE},
      '{8'h61,        1'b0, 1'b0, ERR_NONE},
      '{CH_COMMA,     1'b0, 1'b0, ERR_NONE},
      '{CH_QUOTE,     1'b0, 1'b0, ERR_NONE},
      '{8'h62,        1'b0, 1'b0, ERR_NONE},
      '{CH_QUOTE,     1'b0, 1'b0, ERR_NONE},
      '{CH_RBRACKET,  1'b1, 1'b0, ERR_NONE},
      '{8'hff,        1'b1, 1'b0, ERR_NONE},
      '{CH_LBRACE,    1'b0, 1'b0, ERR_NONE},
      '{CH_LBRACKET,  1'b0, 1'b0, ERR_NONE},
      '{CH_RBRACE,    1'b1, 1'b1, ERR_SYNTAX},
      '{CH_TAB,       1'b0, 1'b0, ERR_NONE},
      '{8'h37,        1'b0, 1'b0, ERR_NONE},
      '{CH_CR,        1'b0, 1'b0, ERR_NONE},
      '{CH_LF,        1'b1, 1'b0, ERR_NONE}
   };

   initial begin
      int sent;
      limit_reg = LIMIT_RESET;
      clear_scan();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (doc_tab[i]) begin
         send_byte(doc_tab[i].b, doc_tab[i].last);
         if (doc_tab[i].chk && last_status != doc_tab[i].st) begin
            $display("%0t mismatch directed status expected %0d actual %0d",
                     $time, doc_tab[i].st, last_status);
            fails++;
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 10 : (ph == 1) ? 58 : 0;
         stall_pct = (ph == 0) ? 58 : (ph == 1) ? 10 : 0;
         write_limit((ph == 0) ? 1 : (ph == 1) ? 5 : 32);
         sent = 0;
         while (sent < 95) begin
            build_doc();
            foreach (doc_q[i])
               send_byte(doc_q[i], i == doc_q.size() - 1);
            sent += doc_q.size();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fails == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
